@@ src/swmh_pkg.sv @@
// ----------------------------------------------------------------------------
// swmh_pkg
// Shared types and constants for the sliding-window minimum heap block.
// ----------------------------------------------------------------------------
package swmh_pkg;

   localparam int WINDOW_MAX = 1024;
   localparam int POS_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W      = POS_W + 1;
   localparam int SAMPLE_W   = 32;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      pos_type                    slot;
   } node_type;

   // Heap store read addresses: port a for parent or left child, b for right child.
   typedef struct packed {
      pos_type addr_a;
      pos_type addr_b;
   } heap_rd_type;

   typedef struct packed {
      logic     en;
      pos_type  addr;
      node_type node;
   } heap_wr_type;

   typedef struct packed {
      logic    en;
      pos_type slot;
      pos_type pos;
   } map_wr_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_LOOKUP   = 7'b0000010,
      ST_UP_RD    = 7'b0000100,
      ST_UP_CMP   = 7'b0001000,
      ST_DOWN_RD  = 7'b0010000,
      ST_DOWN_CMP = 7'b0100000,
      ST_WRITE    = 7'b1000000
   } state_type;

endpackage

@@ src/swmh_if.sv @@
// ----------------------------------------------------------------------------
// swmh channel interfaces
// Valid/ready channels for samples, results and the window size register.
// ----------------------------------------------------------------------------
interface swmh_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [swmh_pkg::SAMPLE_W-1:0] sample;
   logic                                 restart;
   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swmh_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [swmh_pkg::SAMPLE_W-1:0] window_min;
   modport source (output valid, output window_min, input ready);
   modport sink   (input valid, input window_min, output ready);
endinterface

interface swmh_csr_if;
   logic                        valid;
   logic                        ready;
   logic [swmh_pkg::CNT_W-1:0]  window_size;
   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

@@ src/sliding_window_minimum_heap.sv @@
// Each heap level sifted costs a registered read, then a compare and move; every
// sample also takes a root check and a final write, and a replacing sample a slot
// lookup first. One sample in work at a time: the next is taken only after the
// final write, which is held while a waiting result is still unread.
// Reset (synchronous, active high) empties the window and sets window_size to 1;
// heap memories are not cleared, the fill count guards them.
// ----------------------------------------------------------------------------
// sliding_window_minimum_heap
// Sliding-window minimum over signed samples kept in an indexed binary min-heap.
// ----------------------------------------------------------------------------
module sliding_window_minimum_heap (
   input  logic       clock,
   input  logic       reset,
   swmh_req_if.sink   req_chan,
   swmh_rsp_if.source rsp_chan,
   swmh_csr_if.sink   csr_chan
);

   swmh_pkg::state_type state_ff, state_in;
   swmh_pkg::cnt_type   win_size_ff, win_size_in;
   swmh_pkg::cnt_type   fill_ff, fill_in;
   swmh_pkg::pos_type   oldest_ff, oldest_in;
   swmh_pkg::pos_type   hole_ff, hole_in;
   swmh_pkg::node_type  item_ff, item_in;
   logic                fill_mode_ff, fill_mode_in;
   logic                emit_ff, emit_in;
   logic signed [swmh_pkg::SAMPLE_W-1:0] root_ff, root_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [swmh_pkg::SAMPLE_W-1:0] rsp_min_ff, rsp_min_in;

   swmh_pkg::heap_rd_type heap_rd;
   swmh_pkg::node_type    heap_rd_a, heap_rd_b;
   swmh_pkg::heap_wr_type heap_wr;
   swmh_pkg::pos_type     map_rd_slot, map_rd_pos;
   swmh_pkg::map_wr_type  map_wr;

   swmh_pkg::cnt_type      n_eff;
   swmh_pkg::pos_type      parent_pos;
   swmh_pkg::cnt_type      left_pos;
   logic [swmh_pkg::CNT_W:0] right_pos;
   logic                   req_acc, csr_acc, out_free;
   logic                   flush;
   swmh_pkg::cnt_type      fill_eff;
   swmh_pkg::pos_type      oldest_eff;
   logic                   take_l, take_r;
   logic signed [swmh_pkg::SAMPLE_W-1:0] cur_min;

   swmh_heap_store u_store (
      .clock       (clock),
      .heap_rd     (heap_rd),
      .heap_rd_a   (heap_rd_a),
      .heap_rd_b   (heap_rd_b),
      .heap_wr     (heap_wr),
      .map_rd_slot (map_rd_slot),
      .map_rd_pos  (map_rd_pos),
      .map_wr      (map_wr)
   );

   // Window size 0 acts as 1, oversize clamps to the heap depth.
   always_comb begin
      if (win_size_ff == '0) begin
         n_eff = swmh_pkg::cnt_type'(1);
      end else if (win_size_ff > swmh_pkg::cnt_type'(swmh_pkg::WINDOW_MAX)) begin
         n_eff = swmh_pkg::cnt_type'(swmh_pkg::WINDOW_MAX);
      end else begin
         n_eff = win_size_ff;
      end
   end

   assign csr_chan.ready = (state_ff == swmh_pkg::ST_IDLE);
   assign req_chan.ready = (state_ff == swmh_pkg::ST_IDLE) && !csr_chan.valid;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_acc        = csr_chan.valid && csr_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.window_min = rsp_min_ff;

   assign parent_pos = (hole_ff - swmh_pkg::pos_type'(1)) >> 1;
   assign left_pos   = {hole_ff, 1'b1};
   assign right_pos  = {1'b0, hole_ff, 1'b0} + (swmh_pkg::CNT_W+1)'(2);

   assign flush      = req_chan.restart || (fill_ff > n_eff);
   assign fill_eff   = flush ? '0 : fill_ff;
   assign oldest_eff = (flush || ({1'b0, oldest_ff} >= n_eff)) ? '0 : oldest_ff;

   // Sift-down choice: left child wins ties against the right.
   assign take_l  = item_ff.value > heap_rd_a.value;
   assign cur_min = take_l ? heap_rd_a.value : item_ff.value;
   assign take_r  = (right_pos < {1'b0, n_eff}) && (cur_min > heap_rd_b.value);

   always_comb begin
      state_in     = state_ff;
      win_size_in  = win_size_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      hole_in      = hole_ff;
      item_in      = item_ff;
      fill_mode_in = fill_mode_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_min_in   = rsp_min_ff;
      heap_rd      = '{addr_a: '0, addr_b: '0};
      heap_wr      = '{en: 1'b0, addr: '0, node: item_ff};
      map_rd_slot  = oldest_eff;
      map_wr       = '{en: 1'b0, slot: item_ff.slot, pos: hole_ff};

      case (state_ff)
         swmh_pkg::ST_IDLE: begin
            if (csr_acc) begin
               win_size_in = csr_chan.window_size;
               fill_in     = '0;
               oldest_in   = '0;
            end else if (req_acc) begin
               item_in.value = req_chan.sample;
               if (fill_eff < n_eff) begin
                  hole_in       = fill_eff[swmh_pkg::POS_W-1:0];
                  item_in.slot  = fill_eff[swmh_pkg::POS_W-1:0];
                  fill_in       = fill_eff + swmh_pkg::cnt_type'(1);
                  oldest_in     = oldest_eff;
                  fill_mode_in  = 1'b1;
                  emit_in       = (fill_eff + swmh_pkg::cnt_type'(1)) == n_eff;
                  state_in      = swmh_pkg::ST_UP_RD;
               end else begin
                  item_in.slot  = oldest_eff;
                  fill_in       = fill_eff;
                  oldest_in     = ({1'b0, oldest_eff} + swmh_pkg::cnt_type'(1) == n_eff) ?
                                  '0 : oldest_eff + swmh_pkg::pos_type'(1);
                  fill_mode_in  = 1'b0;
                  emit_in       = 1'b1;
                  state_in      = swmh_pkg::ST_LOOKUP;
               end
            end
         end
         swmh_pkg::ST_LOOKUP: begin
            hole_in  = map_rd_pos;
            state_in = swmh_pkg::ST_UP_RD;
         end
         swmh_pkg::ST_UP_RD: begin
            heap_rd.addr_a = parent_pos;
            if (hole_ff == '0) begin
               state_in = fill_mode_ff ? swmh_pkg::ST_WRITE : swmh_pkg::ST_DOWN_RD;
            end else begin
               state_in = swmh_pkg::ST_UP_CMP;
            end
         end
         swmh_pkg::ST_UP_CMP: begin
            if (heap_rd_a.value > item_ff.value) begin
               heap_wr  = '{en: 1'b1, addr: hole_ff, node: heap_rd_a};
               map_wr   = '{en: 1'b1, slot: heap_rd_a.slot, pos: hole_ff};
               hole_in  = parent_pos;
               state_in = swmh_pkg::ST_UP_RD;
            end else begin
               state_in = fill_mode_ff ? swmh_pkg::ST_WRITE : swmh_pkg::ST_DOWN_RD;
            end
         end
         swmh_pkg::ST_DOWN_RD: begin
            heap_rd.addr_a = left_pos[swmh_pkg::POS_W-1:0];
            heap_rd.addr_b = right_pos[swmh_pkg::POS_W-1:0];
            state_in = (left_pos < n_eff) ? swmh_pkg::ST_DOWN_CMP : swmh_pkg::ST_WRITE;
         end
         swmh_pkg::ST_DOWN_CMP: begin
            if (take_r) begin
               heap_wr  = '{en: 1'b1, addr: hole_ff, node: heap_rd_b};
               map_wr   = '{en: 1'b1, slot: heap_rd_b.slot, pos: hole_ff};
               hole_in  = right_pos[swmh_pkg::POS_W-1:0];
               state_in = swmh_pkg::ST_DOWN_RD;
            end else if (take_l) begin
               heap_wr  = '{en: 1'b1, addr: hole_ff, node: heap_rd_a};
               map_wr   = '{en: 1'b1, slot: heap_rd_a.slot, pos: hole_ff};
               hole_in  = left_pos[swmh_pkg::POS_W-1:0];
               state_in = swmh_pkg::ST_DOWN_RD;
            end else begin
               state_in = swmh_pkg::ST_WRITE;
            end
         end
         swmh_pkg::ST_WRITE: begin
            // Hold here while a previous result is still waiting.
            if (!emit_ff || out_free) begin
               heap_wr  = '{en: 1'b1, addr: hole_ff, node: item_ff};
               map_wr   = '{en: 1'b1, slot: item_ff.slot, pos: hole_ff};
               state_in = swmh_pkg::ST_IDLE;
               if (emit_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_min_in   = (hole_ff == '0) ? item_ff.value : root_ff;
               end
            end
         end
         default: begin
            state_in = swmh_pkg::ST_IDLE;
         end
      endcase
   end

   // Track the heap root so the result needs no extra memory read.
   assign root_in = (heap_wr.en && heap_wr.addr == '0) ? heap_wr.node.value : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swmh_pkg::ST_IDLE;
         win_size_ff  <= swmh_pkg::cnt_type'(1);
         fill_ff      <= '0;
         oldest_ff    <= '0;
         fill_mode_ff <= 1'b0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_size_ff  <= win_size_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         fill_mode_ff <= fill_mode_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff    <= hole_in;
      item_ff    <= item_in;
      root_ff    <= root_in;
      rsp_min_ff <= rsp_min_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_chan.ready)
      else $error("sample accepted while a previous one is in work");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == swmh_pkg::ST_WRITE))
      else $error("result raised outside the final write step");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == swmh_pkg::ST_DOWN_CMP) |-> ({1'b0, hole_ff} < n_eff))
      else $error("sift-down hole outside the window");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != swmh_pkg::ST_IDLE) |-> (fill_ff <= n_eff && fill_ff != '0))
      else $error("fill count out of range during sift");
`endif

endmodule

@@ src/swmh_heap_store.sv @@
// ----------------------------------------------------------------------------
// swmh_heap_store
// Heap entry memory (two read ports, one write) and slot-to-position map
// (one read, one write). Read data is registered.
// ----------------------------------------------------------------------------
module swmh_heap_store (
   input  logic                  clock,
   input  swmh_pkg::heap_rd_type heap_rd,
   output swmh_pkg::node_type    heap_rd_a,
   output swmh_pkg::node_type    heap_rd_b,
   input  swmh_pkg::heap_wr_type heap_wr,
   input  swmh_pkg::pos_type     map_rd_slot,
   output swmh_pkg::pos_type     map_rd_pos,
   input  swmh_pkg::map_wr_type  map_wr
);

   swmh_pkg::node_type heap_mem [swmh_pkg::WINDOW_MAX];
   swmh_pkg::pos_type  map_mem  [swmh_pkg::WINDOW_MAX];

   always_ff @(posedge clock) begin
      if (heap_wr.en) begin
         heap_mem[heap_wr.addr] <= heap_wr.node;
      end
      heap_rd_a <= heap_mem[heap_rd.addr_a];
      heap_rd_b <= heap_mem[heap_rd.addr_b];
   end

   always_ff @(posedge clock) begin
      if (map_wr.en) begin
         map_mem[map_wr.slot] <= map_wr.pos;
      end
      map_rd_pos <= map_mem[map_rd_slot];
   end

endmodule
